// File: sv/bcs_pkg.sv
`default_nettype none
package bcs_pkg;
    localparam int DefaultMaxPoints = 256;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] REG_PHASE_INC = 3'd0;
    localparam logic [2:0] REG_SYNC_EN   = 3'd1;
    localparam logic [2:0] REG_DIV_IDX   = 3'd2;
    localparam logic [2:0] REG_FLOOR     = 3'd3;
    localparam logic [2:0] REG_MID       = 3'd4;
    localparam logic [2:0] REG_CEILING   = 3'd5;

    localparam logic [31:0] PHASE_INC_RESET = 32'd89478;
    localparam logic [3:0]  DIV_IDX_RESET   = 4'd3;
    localparam logic [3:0]  DIV_IDX_MAX     = 4'd8;
    localparam logic [15:0] FLOOR_RESET     = 16'd16384;
    localparam logic [15:0] MID_RESET       = 16'd32768;
    localparam logic [15:0] CEILING_RESET   = 16'd49152;
    localparam logic [15:0] EMPTY_VALUE     = 16'h8000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic        reset_pulse;
        logic        transport_playing;
        logic [31:0] song_position;
        logic        override_valid;
        logic [15:0] override_position;
    } in_item_t;

    typedef struct packed {
        logic [15:0] curve_value;
        logic        trigger_floor;
        logic        trigger_mid;
        logic        trigger_ceiling;
        logic [15:0] playhead_position;
        logic [8:0]  point_count;
        logic        table_full;
    } out_item_t;
endpackage
`default_nettype wire

// File: sv/bcs_if.sv
`default_nettype none
interface bcs_in_if;
    logic                valid;
    logic                ready;
    bcs_pkg::in_item_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bcs_out_if;
    logic                valid;
    logic                ready;
    bcs_pkg::out_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/breakpoint_curve_sequencer_top.sv
`default_nettype none
// channel    dir   payload                      handshake
// in_item    in    operation, point, tick data  valid/ready
// out_item   out   curve, triggers, status      valid/ready
// cfg        in    we, index, data              write enable only
//
// one transaction at a time through a small sequencer and one memory port
// load: decode, a read and a write per shifted entry, end of the search, insert (full table: no insert)
// tick: decode, scan, read of the lower neighbor, divide (start, 32 quotient bits, done),
//   threshold; where no interpolation is needed the later steps are skipped up to threshold
// clear and unused codes: decode only; result held until out_item.ready
// reset clears the count, accumulator and flags and loads the configuration defaults; the table needs no clearing
module breakpoint_curve_sequencer_top #(
    parameter int MaxPoints = bcs_pkg::DefaultMaxPoints
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bcs_in_if.sink           in_item,
    bcs_out_if.source        out_item,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import bcs_pkg::*;

    localparam int AddrW = $clog2(MaxPoints);
    localparam int CntW  = $clog2(MaxPoints + 1);
    localparam logic [CntW-1:0] MaxCount = CntW'(MaxPoints);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_SHIFT_RD = 10'b0000000100,
        S_SHIFT_WR = 10'b0000001000,
        S_INSERT = 10'b0000010000,
        S_SCAN   = 10'b0000100000,
        S_PREV   = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_THRESH = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [31:0] phase_inc_reg;
    logic        sync_en_reg;
    logic [3:0]  div_idx_reg;
    logic [15:0] floor_reg, mid_reg, ceiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= PHASE_INC_RESET;
            sync_en_reg   <= 1'b0;
            div_idx_reg   <= DIV_IDX_RESET;
            floor_reg     <= FLOOR_RESET;
            mid_reg       <= MID_RESET;
            ceiling_reg   <= CEILING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_INC: phase_inc_reg <= cfg_data;
                REG_SYNC_EN:   sync_en_reg   <= cfg_data[0];
                REG_DIV_IDX:   div_idx_reg   <= cfg_data[3:0];
                REG_FLOOR:     floor_reg     <= cfg_data[15:0];
                REG_MID:       mid_reg       <= cfg_data[15:0];
                REG_CEILING:   ceiling_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // block state
    in_item_t        item_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic [31:0]     acc_reg, acc_next;
    logic [2:0]      above_reg, above_next;
    logic            playing_reg, playing_next;
    logic [CntW-1:0] pos_reg, pos_next;
    logic [15:0]     x2_reg, x2_next, y2_reg, y2_next;
    logic [15:0]     x1_reg, x1_next, y1_reg, y1_next;
    out_item_t       res_reg, res_next;

    // memory port
    logic             mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [31:0]      mem_wdata, mem_rdata;

    bcs_point_table #(.MaxPoints(MaxPoints), .AddrW(AddrW)) u_table (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // divider, started once both neighbors sit in registers
    logic        div_start, div_busy, div_done;
    logic [31:0] div_dividend, div_quot;
    logic [15:0] div_divisor;

    bcs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .busy     (div_busy),
        .done     (div_done)
    );

    logic [15:0] ph;
    logic [15:0] rd_x, rd_y;
    logic [3:0]  div_eff;
    logic [47:0] sync_shift;
    logic [16:0] dy_abs;
    logic [15:0] dx_num;
    logic [32:0] prod;
    logic [15:0] curve;
    logic        in_fire;

    assign ph      = acc_reg[31:16];
    assign rd_x    = mem_rdata[31:16];
    assign rd_y    = mem_rdata[15:0];
    assign in_fire = in_item.valid && in_item.ready;
    assign in_item.ready  = (state_reg == S_IDLE);
    assign out_item.valid = (state_reg == S_OUT);
    assign out_item.payload = res_reg;

    always_comb
    begin
        div_eff    = (div_idx_reg > DIV_IDX_MAX) ? DIV_IDX_MAX : div_idx_reg;
        sync_shift = {16'd0, item_reg.song_position} << (5'd11 + {1'b0, div_eff});
        // dy magnitude and x offset for the interpolation
        if (y2_reg >= y1_reg)
            dy_abs = {1'b0, y2_reg - y1_reg};
        else
            dy_abs = {1'b0, y1_reg - y2_reg};
        dx_num = ph - x1_reg;
        prod   = {16'd0, dy_abs} * {17'd0, dx_num};
    end

    assign div_dividend = prod[31:0];
    assign div_divisor  = x2_reg - x1_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        above_next   = above_reg;
        playing_next = playing_reg;
        pos_next     = pos_reg;
        x1_next = x1_reg; y1_next = y1_reg;
        x2_next = x2_reg; y2_next = y2_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_addr     = pos_reg[AddrW-1:0];
        mem_wdata    = {item_reg.point_x, item_reg.point_y};
        div_start    = 1'b0;
        curve        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                res_next = '0;
                res_next.playhead_position = ph;
                res_next.point_count = 9'(count_reg);
                pos_next = count_reg;
                case (item_reg.operation)
                    OP_LOAD:
                    begin
                        if (count_reg == MaxCount)
                        begin
                            res_next.table_full = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_SHIFT_RD;
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        above_next = '0;
                        res_next.point_count = '0;
                        state_next = S_OUT;
                    end
                    OP_TICK:
                    begin
                        logic [31:0] a;
                        a = acc_reg;
                        if (item_reg.transport_playing && !playing_reg)
                            a = '0;
                        playing_next = item_reg.transport_playing;
                        if (item_reg.reset_pulse)
                            a = '0;
                        if (item_reg.override_valid)
                            a = {item_reg.override_position, 16'd0};
                        else if (sync_en_reg && item_reg.transport_playing)
                            a = sync_shift[31:0];
                        else
                            a = a + phase_inc_reg;
                        acc_next = a;
                        pos_next = '0;
                        if (count_reg == '0)
                        begin
                            res_next.curve_value = EMPTY_VALUE;
                            state_next = S_THRESH;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            // insertion: read entry pos-1, move it up if larger than the new x
            S_SHIFT_RD:
            begin
                if (pos_reg == '0)
                    state_next = S_INSERT;
                else
                begin
                    mem_addr   = AddrW'(pos_reg - 1'b1);
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                if (rd_x > item_reg.point_x)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_SHIFT_RD;
                end
                else
                    state_next = S_INSERT;
            end
            S_INSERT:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
                res_next.point_count = 9'(count_reg + 1'b1);
                state_next = S_OUT;
            end
            // scan: address pos issued, data of pos-1 arriving
            S_SCAN:
            begin
                mem_addr = pos_reg[AddrW-1:0];
                if (pos_reg != '0)
                begin
                    x2_next = rd_x;
                    y2_next = rd_y;
                end
                if (pos_reg != '0 && rd_x >= ph)
                begin
                    // first entry with x >= p sits at pos-1
                    if (pos_reg == CntW'(1) || count_reg == CntW'(1))
                    begin
                        res_next.curve_value = rd_y;
                        state_next = S_THRESH;
                    end
                    else
                    begin
                        mem_addr   = AddrW'(pos_reg - 2'd2);
                        state_next = S_PREV;
                    end
                end
                else if (pos_reg == count_reg)
                begin
                    res_next.curve_value = rd_y;
                    state_next = S_THRESH;
                end
                else
                    pos_next = pos_reg + 1'b1;
            end
            S_PREV:
            begin
                x1_next = rd_x;
                y1_next = rd_y;
                if (x2_reg <= rd_x)
                begin
                    res_next.curve_value = y2_reg;
                    state_next = S_THRESH;
                end
                else
                    state_next = S_DIV;
            end
            // first cycle starts the divider, then wait for its done pulse
            S_DIV:
            begin
                if (div_done)
                begin
                    if (y2_reg >= y1_reg)
                        curve = y1_reg + div_quot[15:0];
                    else
                        curve = y1_reg - div_quot[15:0];
                    res_next.curve_value = curve;
                    state_next = S_THRESH;
                end
                else if (!div_busy)
                    div_start = 1'b1;
            end
            S_THRESH:
            begin
                logic [2:0] ab;
                ab[0] = res_reg.curve_value >= floor_reg;
                ab[1] = res_reg.curve_value >= mid_reg;
                ab[2] = res_reg.curve_value >= ceiling_reg;
                res_next.trigger_floor   = ab[0] && !above_reg[0];
                res_next.trigger_mid     = ab[1] && !above_reg[1];
                res_next.trigger_ceiling = ab[2] && !above_reg[2];
                res_next.playhead_position = ph;
                above_next = ab;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_item.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            acc_reg     <= '0;
            above_reg   <= '0;
            playing_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            above_reg   <= above_next;
            playing_reg <= playing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_item.payload;
        pos_reg <= pos_next;
        x1_reg  <= x1_next;
        y1_reg  <= y1_next;
        x2_reg  <= x2_next;
        y2_reg  <= y2_next;
        res_reg <= res_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MaxCount) else $error("point count above capacity");
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIV) else $error("divider busy outside divide");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && !out_item.ready |=> $stable(res_reg))
        else $error("result changed while stalled");
    a_full_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && res_reg.table_full |-> item_reg.operation == OP_LOAD)
        else $error("table_full on non-load");
endmodule
`default_nettype wire

// File: sv/bcs_divider.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, unsigned 32/16
module bcs_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic [31:0]      quotient,
    output logic             busy,
    output logic             done
);
    logic [31:0] quot_reg, quot_next;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        trial     = {rem_reg[15:0], quot_reg[31]};
        diff      = {1'b0, trial} - {2'b00, divisor};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next  = diff[16:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient = quot_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

// File: sv/bcs_point_table.sv
`default_nettype none
// breakpoint store, one port, registered read
module bcs_point_table #(
    parameter int MaxPoints = bcs_pkg::DefaultMaxPoints,
    parameter int AddrW     = $clog2(MaxPoints)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] addr,
    input  wire logic [31:0]      wdata,
    output logic [31:0]           rdata
);
    logic [31:0] mem [MaxPoints];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
